FILE: src/clint_pkg.sv
package clint_pkg;

    // action codes of one request
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    // access size codes
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    localparam int DATA_W = 64;
    localparam int IRQ_W  = 4;

    // one request as it travels from the input stage to the execute logic
    typedef struct packed {
        logic [1:0]        action;
        logic [15:0]       offset;
        logic [1:0]        size;
        logic              sign_extend;
        logic [DATA_W-1:0] write_data;
    } req_t;

    // one response as it leaves the execute logic
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  soft_irq;
        logic [IRQ_W-1:0]  timer_irq;
    } rsp_t;

    // byte lane mask for an access size
    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
        logic [DATA_W-1:0] m;
        case (sz)
            SIZE_BYTE:  m = 64'h0000_0000_0000_00ff;
            SIZE_HALF:  m = 64'h0000_0000_0000_ffff;
            SIZE_WORD:  m = 64'h0000_0000_ffff_ffff;
            default:    m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

FILE: src/core_local_interruptor.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | action, offset, size, sign_extend, write_data
// out      | out_valid / out_ready| read_data, soft_irq, timer_irq
//
// one request per clock sustained while out_ready holds; a request's response
// passes the input register, then the result register, before it is valid
// every register access and all per-core timer compares run combinationally
// between the input register and the result register
// rst_n clears mtime, pending bits and prescaler and sets every compare to all ones
// a stalled output keeps its response; the input register still takes one
// more request, then in_ready drops until the output moves
module core_local_interruptor #(
    parameter int CORE_COUNT     = 4,
    parameter int TICKS_PER_STEP = 4,
    parameter int TIME_STEP      = 3,
    parameter int MSIP_BASE      = 0,
    parameter int TIMECMP_BASE   = 16384,
    parameter int TIME_OFFSET    = 49144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] offset,
    input  logic [1:0]  size,
    input  logic        sign_extend,
    input  logic [63:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic [3:0]  soft_irq,
    output logic [3:0]  timer_irq
);
    import clint_pkg::*;

    logic in_valid_reg, in_valid_next;
    req_t req_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp;
    logic advance;

    // a request moves to the result register when that is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // stage valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.action      <= action;
            req_reg.offset      <= offset;
            req_reg.size        <= size;
            req_reg.sign_extend <= sign_extend;
            req_reg.write_data  <= write_data;
        end
        if (advance)
        begin
            rsp_reg <= rsp;
        end
    end

    clint_exec #(
        .CORE_COUNT     (CORE_COUNT),
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .TIME_STEP      (TIME_STEP),
        .MSIP_BASE      (MSIP_BASE),
        .TIMECMP_BASE   (TIMECMP_BASE),
        .TIME_OFFSET    (TIME_OFFSET)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (advance),
        .req       (req_reg),
        .rsp       (rsp)
    );

    assign out_valid = out_valid_reg;
    assign read_data = rsp_reg.read_data;
    assign soft_irq  = rsp_reg.soft_irq;
    assign timer_irq = rsp_reg.timer_irq;

    // a held request is never dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage lost a request");

    // every advanced request shows up as a response
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request gave no response");

    // a stalled response stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(rsp_reg))
        else $error("stalled response changed");

endmodule

FILE: src/clint_exec.sv
module clint_exec #(
    parameter int CORE_COUNT     = 4,
    parameter int TICKS_PER_STEP = 4,
    parameter int TIME_STEP      = 3,
    parameter int MSIP_BASE      = 0,
    parameter int TIMECMP_BASE   = 16384,
    parameter int TIME_OFFSET    = 49144
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  clint_pkg::req_t req,
    output clint_pkg::rsp_t rsp
);
    import clint_pkg::*;

    localparam int IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int PS_W  = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
    localparam int PAD_W = (CORE_COUNT > IRQ_W) ? CORE_COUNT : IRQ_W;

    localparam logic [17:0] MSIP_LO  = 18'(MSIP_BASE);
    localparam logic [17:0] MSIP_HI  = 18'(MSIP_BASE + 4 * CORE_COUNT);
    localparam logic [17:0] CMP_LO   = 18'(TIMECMP_BASE);
    localparam logic [17:0] CMP_HI   = 18'(TIMECMP_BASE + 8 * CORE_COUNT);
    localparam logic [15:0] TIME_ADR = 16'(TIME_OFFSET);
    localparam logic [PS_W-1:0] PS_LAST = PS_W'(TICKS_PER_STEP - 1);
    localparam logic [DATA_W-1:0] STEP  = DATA_W'(TIME_STEP);

    logic [DATA_W-1:0]     mtime_reg, mtime_next;
    logic [DATA_W-1:0]     cmp_reg  [CORE_COUNT];
    logic [DATA_W-1:0]     cmp_next [CORE_COUNT];
    logic [CORE_COUNT-1:0] soft_reg, soft_next;
    logic [CORE_COUNT-1:0] timer_reg, timer_next;
    logic [PS_W-1:0]       prescale_reg, prescale_next;

    logic [17:0]       addr;
    logic [17:0]       addr_al;
    logic [17:0]       msip_diff;
    logic [17:0]       cmp_diff;
    logic              hit_msip;
    logic              hit_cmp;
    logic              hit_time;
    logic [IDX_W-1:0]  msip_id;
    logic [IDX_W-1:0]  cmp_id;
    logic [5:0]        sh;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] lane_m;
    logic [DATA_W-1:0] lane_d;
    logic [DATA_W-1:0] mtime_plus;
    logic              step_en;
    logic              is_write;
    logic [DATA_W-1:0] rd_raw;
    logic [DATA_W-1:0] rd_ext;
    logic [PAD_W-1:0]  soft_pad;
    logic [PAD_W-1:0]  timer_pad;

    // address decode, checked in priority order
    assign addr      = {2'b00, req.offset};
    assign addr_al   = {2'b00, req.offset[15:3], 3'b000};
    assign msip_diff = addr - MSIP_LO;
    assign cmp_diff  = addr_al - CMP_LO;
    assign hit_msip  = (addr >= MSIP_LO) && (addr < MSIP_HI);
    assign hit_cmp   = !hit_msip && (addr_al >= CMP_LO) && (addr_al < CMP_HI);
    assign hit_time  = !hit_msip && !hit_cmp && (addr_al[15:0] == TIME_ADR);
    assign msip_id   = msip_diff[IDX_W+1:2];
    assign cmp_id    = cmp_diff[IDX_W+2:3];

    // byte lanes of a write
    assign sh     = {req.offset[2:0], 3'b000};
    assign mask   = size_mask(req.size);
    assign lane_m = mask << sh;
    assign lane_d = (req.write_data & mask) << sh;

    assign mtime_plus = mtime_reg + STEP;
    assign step_en    = req_valid && (req.action == ACT_TICK) && (prescale_reg == PS_LAST);
    assign is_write   = req_valid && (req.action == ACT_WRITE);

    // next state for tick and write
    always_comb
    begin
        mtime_next    = mtime_reg;
        cmp_next      = cmp_reg;
        soft_next     = soft_reg;
        timer_next    = timer_reg;
        prescale_next = prescale_reg;
        if (req_valid)
        begin
            case (req.action)
                ACT_TICK:
                begin
                    if (prescale_reg == PS_LAST)
                    begin
                        mtime_next    = mtime_plus;
                        prescale_next = '0;
                        for (int i = 0; i < CORE_COUNT; i++)
                        begin
                            timer_next[i] = (mtime_plus >= cmp_reg[i]);
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_reg + 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    if (hit_msip)
                    begin
                        soft_next[msip_id] = |(req.write_data & mask);
                    end
                    else if (hit_cmp)
                    begin
                        cmp_next[cmp_id] = (cmp_reg[cmp_id] & ~lane_m) | lane_d;
                    end
                    else if (hit_time)
                    begin
                        mtime_next = (mtime_reg & ~lane_m) | lane_d;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtime_reg    <= '0;
            soft_reg     <= '0;
            timer_reg    <= '0;
            prescale_reg <= '0;
            for (int i = 0; i < CORE_COUNT; i++)
            begin
                cmp_reg[i] <= '1;
            end
        end
        else
        begin
            mtime_reg    <= mtime_next;
            cmp_reg      <= cmp_next;
            soft_reg     <= soft_next;
            timer_reg    <= timer_next;
            prescale_reg <= prescale_next;
        end
    end

    // read source; compare and mtime reads are shifted to the addressed byte
    always_comb
    begin
        rd_raw = '0;
        if (hit_msip)
        begin
            rd_raw = DATA_W'(soft_reg[msip_id]);
        end
        else if (hit_cmp)
        begin
            rd_raw = cmp_reg[cmp_id] >> sh;
        end
        else if (hit_time)
        begin
            rd_raw = mtime_reg >> sh;
        end
    end

    // size extension of the read
    always_comb
    begin
        case (req.size)
            SIZE_BYTE:
                rd_ext = {{56{req.sign_extend & rd_raw[7]}}, rd_raw[7:0]};
            SIZE_HALF:
                rd_ext = {{48{req.sign_extend & rd_raw[15]}}, rd_raw[15:0]};
            SIZE_WORD:
                rd_ext = {{32{req.sign_extend & rd_raw[31]}}, rd_raw[31:0]};
            default:
                rd_ext = rd_raw;
        endcase
    end

    // response: pending bits after this request
    assign soft_pad      = PAD_W'(soft_next);
    assign timer_pad     = PAD_W'(timer_next);
    assign rsp.read_data = (req.action == ACT_READ) ? rd_ext : '0;
    assign rsp.soft_irq  = soft_pad[IRQ_W-1:0];
    assign rsp.timer_irq = timer_pad[IRQ_W-1:0];

    // prescaler never passes its last count
    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg <= PS_LAST)
        else $error("prescaler out of range");

    // timer bits move only on an advancing tick
    a_timer_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(timer_reg) |-> $past(step_en))
        else $error("timer pending changed without a time step");

    // software bits move only on a write
    a_soft_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(soft_reg) |-> $past(is_write))
        else $error("software pending changed without a write");

    // mtime moves only on a step or a write
    a_mtime_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(mtime_reg) |-> ($past(step_en) || $past(is_write)))
        else $error("mtime changed without a step or write");

endmodule
